### rtl/core/spic_pkg.sv
// ============================================================================
// spic_pkg
// Types and constants shared by the segment pair intersection check unit.
// ============================================================================
package spic_pkg;

  localparam int COORD_BITS = 16;
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int PROD_BITS  = 2 * DIFF_BITS;
  localparam int CROSS_BITS = PROD_BITS + 1;
  localparam int NUM_ORIENT = 4;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_BITS-1:0]  diff_t;
  typedef logic signed [PROD_BITS-1:0]  prod_t;
  typedef logic signed [CROSS_BITS-1:0] cross_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } point_t;

  // a0/a1: first segment, b0/b1: second segment
  typedef struct packed {
    point_t a0;
    point_t a1;
    point_t b0;
    point_t b1;
  } seg_pair_t;

  // orientation of c against directed line a->b: dbx*dcy - dby*dcx
  typedef struct packed {
    diff_t dbx;
    diff_t dby;
    diff_t dcx;
    diff_t dcy;
  } orient_diff_t;

  typedef struct packed {
    logic [NUM_ORIENT-1:0] in_box;
    logic                  share;
  } flags_t;

  typedef struct packed {
    orient_diff_t [NUM_ORIENT-1:0] od;
    flags_t                        flags;
  } diff_word_t;

  typedef struct packed {
    prod_t [NUM_ORIENT-1:0] p_lhs;
    prod_t [NUM_ORIENT-1:0] p_rhs;
    flags_t                 flags;
  } prod_word_t;

  typedef struct packed {
    logic [NUM_ORIENT-1:0] pos;
    logic [NUM_ORIENT-1:0] neg;
    flags_t                flags;
  } sign_word_t;

  typedef struct packed {
    logic touches_or_crosses;
    logic shares_endpoint;
    logic violation;
  } result_t;

  function automatic logic in_box_f(point_t a, point_t b, point_t c);
    logic gx, lx, gy, ly;
    gx = (c.x >= a.x) || (c.x >= b.x);
    lx = (c.x <= a.x) || (c.x <= b.x);
    gy = (c.y >= a.y) || (c.y >= b.y);
    ly = (c.y <= a.y) || (c.y <= b.y);
    return gx && lx && gy && ly;
  endfunction

  function automatic orient_diff_t orient_diff_f(point_t a, point_t b, point_t c);
    orient_diff_t d;
    d.dbx = diff_t'(b.x) - diff_t'(a.x);
    d.dby = diff_t'(b.y) - diff_t'(a.y);
    d.dcx = diff_t'(c.x) - diff_t'(a.x);
    d.dcy = diff_t'(c.y) - diff_t'(a.y);
    return d;
  endfunction

endpackage

### rtl/core/spic_if.sv
// ============================================================================
// spic_if
// Valid/ready channels of the segment pair intersection check unit.
// ============================================================================
interface spic_in_if;
  import spic_pkg::*;
  logic   valid;
  logic   ready;
  coord_t seg1_start_x;
  coord_t seg1_start_y;
  coord_t seg1_end_x;
  coord_t seg1_end_y;
  coord_t seg2_start_x;
  coord_t seg2_start_y;
  coord_t seg2_end_x;
  coord_t seg2_end_y;

  modport source (
    output valid, seg1_start_x, seg1_start_y, seg1_end_x, seg1_end_y,
    output seg2_start_x, seg2_start_y, seg2_end_x, seg2_end_y,
    input  ready
  );
  modport sink (
    input  valid, seg1_start_x, seg1_start_y, seg1_end_x, seg1_end_y,
    input  seg2_start_x, seg2_start_y, seg2_end_x, seg2_end_y,
    output ready
  );
endinterface

interface spic_out_if;
  logic valid;
  logic ready;
  logic touches_or_crosses;
  logic shares_endpoint;
  logic violation;

  modport source (
    output valid, touches_or_crosses, shares_endpoint, violation,
    input  ready
  );
  modport sink (
    input  valid, touches_or_crosses, shares_endpoint, violation,
    output ready
  );
endinterface

interface spic_cfg_if;
  logic valid;
  logic ready;
  logic data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

### rtl/core/segment_pair_intersection_check_unit.sv
// ============================================================================
// segment_pair_intersection_check_unit
// Decides whether two integer 2D segments cross or touch, and whether the
// touch is excused by a shared endpoint under the configured mode.
// ============================================================================
// Usage:
//   in_ch   : one word per segment pair (two endpoints of each segment).
//   out_ch  : one word per input word, in order: touches_or_crosses,
//             shares_endpoint, violation.
//   cfg_ch  : one-bit allow_shared_vertex, always ready; write it only while
//             no word is in flight. 1 excuses a touch at a common endpoint.
//   Throughput: one word per cycle, sustained while out_ch.ready stays high.
//   Pipeline registers, in order: differences, products,
//   cross product signs, result register.
//   Reset (rst_n low, synchronous): all stages empty, allow_shared_vertex
//   cleared to 0.
//   Stall: when out_ch.ready is low, the result register holds its word and
//   the stages fill up behind it; in_ch.ready drops only once every stage
//   holds a word. Nothing is dropped or repeated.
// ============================================================================
module segment_pair_intersection_check_unit (
  input  logic             clk,
  input  logic             rst_n,
  spic_in_if.sink          in_ch,
  spic_out_if.source       out_ch,
  spic_cfg_if.sink         cfg_ch
);
  import spic_pkg::*;

  seg_pair_t  in_word;
  logic       s1_vld, s1_rdy;
  diff_word_t s1_data;
  logic       s2_vld, s2_rdy;
  prod_word_t s2_data;
  logic       s3_vld, s3_rdy;
  sign_word_t s3_data;

  logic       mode_r;
  logic       out_vld_r;
  result_t    out_r;
  result_t    out_nxt;
  logic       hit;

  assign in_word.a0.x = in_ch.seg1_start_x;
  assign in_word.a0.y = in_ch.seg1_start_y;
  assign in_word.a1.x = in_ch.seg1_end_x;
  assign in_word.a1.y = in_ch.seg1_end_y;
  assign in_word.b0.x = in_ch.seg2_start_x;
  assign in_word.b0.y = in_ch.seg2_start_y;
  assign in_word.b1.x = in_ch.seg2_end_x;
  assign in_word.b1.y = in_ch.seg2_end_y;

  spic_prep u_prep (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (in_ch.valid),
    .rdy_o  (in_ch.ready),
    .data_i (in_word),
    .vld_o  (s1_vld),
    .rdy_i  (s1_rdy),
    .data_o (s1_data)
  );

  spic_mult u_mult (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (s1_vld),
    .rdy_o  (s1_rdy),
    .data_i (s1_data),
    .vld_o  (s2_vld),
    .rdy_i  (s2_rdy),
    .data_o (s2_data)
  );

  spic_orient u_orient (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (s2_vld),
    .rdy_o  (s2_rdy),
    .data_i (s2_data),
    .vld_o  (s3_vld),
    .rdy_i  (s3_rdy),
    .data_o (s3_data)
  );

  // config register
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else if (cfg_ch.valid) begin
      mode_r <= cfg_ch.data;
    end
  end

  // result stage
  always_comb begin
    hit = (((s3_data.pos[0] && s3_data.neg[1]) || (s3_data.neg[0] && s3_data.pos[1])) &&
           ((s3_data.pos[2] && s3_data.neg[3]) || (s3_data.neg[2] && s3_data.pos[3])));
    for (int i = 0; i < NUM_ORIENT; i++) begin
      if (!s3_data.pos[i] && !s3_data.neg[i] && s3_data.flags.in_box[i]) begin
        hit = 1'b1;
      end
    end
    out_nxt.touches_or_crosses = hit;
    out_nxt.shares_endpoint    = s3_data.flags.share;
    out_nxt.violation          = hit && !(mode_r && s3_data.flags.share);
  end

  assign s3_rdy = !out_vld_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s3_rdy) begin
      out_vld_r <= s3_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_rdy && s3_vld) begin
      out_r <= out_nxt;
    end
  end

  assign out_ch.valid              = out_vld_r;
  assign out_ch.touches_or_crosses = out_r.touches_or_crosses;
  assign out_ch.shares_endpoint    = out_r.shares_endpoint;
  assign out_ch.violation          = out_r.violation;

endmodule

### rtl/core/spic_prep.sv
// ============================================================================
// spic_prep
// Stage 1: coordinate differences, bounding box tests, shared endpoint test.
// ============================================================================
module spic_prep (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   vld_i,
  output logic                   rdy_o,
  input  spic_pkg::seg_pair_t    data_i,
  output logic                   vld_o,
  input  logic                   rdy_i,
  output spic_pkg::diff_word_t   data_o
);
  import spic_pkg::*;

  logic       vld_r;
  diff_word_t data_r;
  diff_word_t data_nxt;

  always_comb begin
    data_nxt.od[0] = orient_diff_f(data_i.b0, data_i.b1, data_i.a0);
    data_nxt.od[1] = orient_diff_f(data_i.b0, data_i.b1, data_i.a1);
    data_nxt.od[2] = orient_diff_f(data_i.a0, data_i.a1, data_i.b0);
    data_nxt.od[3] = orient_diff_f(data_i.a0, data_i.a1, data_i.b1);
    data_nxt.flags.in_box[0] = in_box_f(data_i.b0, data_i.b1, data_i.a0);
    data_nxt.flags.in_box[1] = in_box_f(data_i.b0, data_i.b1, data_i.a1);
    data_nxt.flags.in_box[2] = in_box_f(data_i.a0, data_i.a1, data_i.b0);
    data_nxt.flags.in_box[3] = in_box_f(data_i.a0, data_i.a1, data_i.b1);
    data_nxt.flags.share = (data_i.a0 == data_i.b0) || (data_i.a0 == data_i.b1) ||
                           (data_i.a1 == data_i.b0) || (data_i.a1 == data_i.b1);
  end

  assign rdy_o = !vld_r || rdy_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (rdy_o) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_o && vld_i) begin
      data_r <= data_nxt;
    end
  end

  assign vld_o  = vld_r;
  assign data_o = data_r;

endmodule

### rtl/core/spic_mult.sv
// ============================================================================
// spic_mult
// Stage 2: the eight full-width products of the four cross products.
// ============================================================================
module spic_mult (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   vld_i,
  output logic                   rdy_o,
  input  spic_pkg::diff_word_t   data_i,
  output logic                   vld_o,
  input  logic                   rdy_i,
  output spic_pkg::prod_word_t   data_o
);
  import spic_pkg::*;

  logic       vld_r;
  prod_word_t data_r;
  prod_word_t data_nxt;

  always_comb begin
    for (int i = 0; i < NUM_ORIENT; i++) begin
      data_nxt.p_lhs[i] = data_i.od[i].dbx * data_i.od[i].dcy;
      data_nxt.p_rhs[i] = data_i.od[i].dby * data_i.od[i].dcx;
    end
    data_nxt.flags = data_i.flags;
  end

  assign rdy_o = !vld_r || rdy_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (rdy_o) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_o && vld_i) begin
      data_r <= data_nxt;
    end
  end

  assign vld_o  = vld_r;
  assign data_o = data_r;

endmodule

### rtl/core/spic_orient.sv
// ============================================================================
// spic_orient
// Stage 3: cross product differences reduced to sign bits.
// ============================================================================
module spic_orient (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   vld_i,
  output logic                   rdy_o,
  input  spic_pkg::prod_word_t   data_i,
  output logic                   vld_o,
  input  logic                   rdy_i,
  output spic_pkg::sign_word_t   data_o
);
  import spic_pkg::*;

  logic       vld_r;
  sign_word_t data_r;
  sign_word_t data_nxt;
  cross_t     xprod [NUM_ORIENT];

  always_comb begin
    for (int i = 0; i < NUM_ORIENT; i++) begin
      xprod[i] = cross_t'(data_i.p_lhs[i]) - cross_t'(data_i.p_rhs[i]);
      data_nxt.neg[i] = xprod[i][CROSS_BITS-1];
      data_nxt.pos[i] = !xprod[i][CROSS_BITS-1] && (xprod[i] != '0);
    end
    data_nxt.flags = data_i.flags;
  end

  assign rdy_o = !vld_r || rdy_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (rdy_o) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_o && vld_i) begin
      data_r <= data_nxt;
    end
  end

  assign vld_o  = vld_r;
  assign data_o = data_r;

endmodule

### rtl/core/spic_checker.sv
// ============================================================================
// spic_checker
// Port-level checks for the segment pair intersection check unit.
// ============================================================================
module spic_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic touches_or_crosses,
  input logic shares_endpoint,
  input logic violation
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(touches_or_crosses) && $stable(shares_endpoint) &&
      $stable(violation))
    else $error("stalled output word changed");

  a_viol_needs_touch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && violation |-> touches_or_crosses)
    else $error("violation without touch");

  a_viol_no_share: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !shares_endpoint |-> violation == touches_or_crosses)
    else $error("touch without shared endpoint not flagged");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready ##1 out_ready ##1 out_ready ##1 out_ready |=> out_valid)
    else $error("word not delivered within pipeline latency");

endmodule

bind segment_pair_intersection_check_unit spic_checker u_spic_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_ch.valid),
  .in_ready           (in_ch.ready),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .touches_or_crosses (out_ch.touches_or_crosses),
  .shares_endpoint    (out_ch.shares_endpoint),
  .violation          (out_ch.violation)
);
